@@ design/lbgw_pkg.sv @@
// lbgw_pkg: shared constants, codes and structs of the grid line walker
// used by lbgw_ctrl, lbgw_dpath and line_block_grid_walker_core
package lbgw_pkg;

  localparam int BLOCK_SHIFT     = 7;
  localparam int MAX_VISITS      = 64;
  localparam int MAX_GRID_BLOCKS = 262144;

  localparam int CRD_W = 16;
  localparam int DLT_W = 17;
  localparam int ORG_W = 17;
  localparam int GW_W  = 10;
  localparam int GB_W  = 19;
  localparam int CFG_W = 19;
  localparam int LID_W = 16;
  localparam int IDX_W = 18;
  localparam int ST_W  = 2;

  localparam int OFF_W = ORG_W + 1;
  localparam int FLR_W = OFF_W - BLOCK_SHIFT;
  localparam int FRC_W = BLOCK_SHIFT;
  localparam int PRD_W = FRC_W + DLT_W;
  localparam int GRD_W = FLR_W + GW_W + 1;
  localparam int CUR_W = GRD_W + 2;
  localparam int ERR_W = 40;
  localparam int VIS_W = $clog2(MAX_VISITS + 1);

  localparam logic [GB_W-1:0]  GRID_CAP = GB_W'(MAX_GRID_BLOCKS);
  localparam logic [VIS_W-1:0] VIS_CAP  = VIS_W'(MAX_VISITS);

  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_LEFT = 2'd1;
  localparam logic [ST_W-1:0] ST_CAP  = 2'd2;

  localparam logic [1:0] REG_ORIGIN_X    = 2'd0;
  localparam logic [1:0] REG_ORIGIN_Y    = 2'd1;
  localparam logic [1:0] REG_GRID_WIDTH  = 2'd2;
  localparam logic [1:0] REG_GRID_BLOCKS = 2'd3;

  typedef struct packed {
    logic [ORG_W-1:0] origin_x;
    logic [ORG_W-1:0] origin_y;
    logic [GW_W-1:0]  grid_width;
    logic [GB_W-1:0]  grid_blocks;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic sum;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic last;
  } sts_t;

endpackage

@@ design/lbgw_ctrl.sv @@
// lbgw_ctrl: sequencer of the grid line walker, setup then one step per result
// depends on lbgw_pkg
module lbgw_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  lbgw_pkg::sts_t sts_i,
  output lbgw_pkg::cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_SUM  = 2'd2;
  localparam logic [1:0] S_WALK = 2'd3;

  logic [1:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = S_WALK;
      end
      S_WALK: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.last) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ design/lbgw_dpath.sv @@
// lbgw_dpath: offsets, error term setup, walk registers and result register
// depends on lbgw_pkg
module lbgw_dpath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lbgw_pkg::cfg_t              cfg_i,
  input  lbgw_pkg::cmd_t              cmd_i,
  output lbgw_pkg::sts_t              sts_o,
  input  logic [lbgw_pkg::LID_W-1:0]  line_id_i,
  input  logic [lbgw_pkg::CRD_W-1:0]  start_x_i,
  input  logic [lbgw_pkg::CRD_W-1:0]  start_y_i,
  input  logic [lbgw_pkg::CRD_W-1:0]  end_x_i,
  input  logic [lbgw_pkg::CRD_W-1:0]  end_y_i,
  input  logic [lbgw_pkg::DLT_W-1:0]  delta_x_i,
  input  logic [lbgw_pkg::DLT_W-1:0]  delta_y_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [lbgw_pkg::LID_W-1:0]  line_out_o,
  output logic [lbgw_pkg::IDX_W-1:0]  block_index_o,
  output logic                        block_valid_o,
  output logic                        last_o,
  output logic [lbgw_pkg::ST_W-1:0]   status_o
);

  localparam int OFF_W = lbgw_pkg::OFF_W;
  localparam int FLR_W = lbgw_pkg::FLR_W;
  localparam int FRC_W = lbgw_pkg::FRC_W;
  localparam int PRD_W = lbgw_pkg::PRD_W;
  localparam int GRD_W = lbgw_pkg::GRD_W;
  localparam int CUR_W = lbgw_pkg::CUR_W;
  localparam int ERR_W = lbgw_pkg::ERR_W;
  localparam int VIS_W = lbgw_pkg::VIS_W;
  localparam int DLT_W = lbgw_pkg::DLT_W;
  localparam int CRD_W = lbgw_pkg::CRD_W;
  localparam int BS    = lbgw_pkg::BLOCK_SHIFT;

  // input stage
  logic [OFF_W-1:0] ox, oy, oex, oey, orgx, orgy;
  logic [DLT_W-1:0] adx, ady;
  logic             sx_neg, sy_neg;

  logic [FLR_W-1:0] xb_q, yb_q, exb_q, eyb_q;
  logic [FRC_W-1:0] a_q, b_q;
  logic [DLT_W-1:0] adx_q, ady_q;
  logic             sx_neg_q, sy_neg_q;
  logic [lbgw_pkg::LID_W-1:0] line_q;

  // product stage
  logic [PRD_W-1:0] p1_q, p2_q;
  logic signed [GRD_W-1:0] pc_q, pe_q, ybe, eybe, gwe;

  // walk registers
  logic [ERR_W-1:0] err_q, err_d, xdel_q, ydel_q;
  logic [CUR_W-1:0] cur_q, cur_d, end_q, ystep_q, gwx;
  logic             xneg_q;
  logic [VIS_W-1:0] visit_q, visit_nx;

  logic [lbgw_pkg::GB_W-1:0] tot;
  logic left, at_end, at_cap;

  logic out_valid_q;
  logic [lbgw_pkg::IDX_W-1:0] idx_q;
  logic vld_q, last_q;
  logic [lbgw_pkg::ST_W-1:0] st_q;

  assign orgx   = {cfg_i.origin_x[lbgw_pkg::ORG_W-1], cfg_i.origin_x};
  assign orgy   = {cfg_i.origin_y[lbgw_pkg::ORG_W-1], cfg_i.origin_y};
  assign ox     = {{2{start_x_i[CRD_W-1]}}, start_x_i} - orgx;
  assign oy     = {{2{start_y_i[CRD_W-1]}}, start_y_i} - orgy;
  assign oex    = {{2{end_x_i[CRD_W-1]}}, end_x_i} - orgx;
  assign oey    = {{2{end_y_i[CRD_W-1]}}, end_y_i} - orgy;
  assign sx_neg = delta_x_i[DLT_W-1];
  assign sy_neg = delta_y_i[DLT_W-1];
  assign adx    = sx_neg ? (~delta_x_i + DLT_W'(1)) : delta_x_i;
  assign ady    = sy_neg ? (~delta_y_i + DLT_W'(1)) : delta_y_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      xb_q     <= ox[OFF_W-1:BS];
      yb_q     <= oy[OFF_W-1:BS];
      exb_q    <= oex[OFF_W-1:BS];
      eyb_q    <= oey[OFF_W-1:BS];
      // distance to the far edge of the block in the step direction
      a_q      <= sx_neg ? ox[BS-1:0] : ~ox[BS-1:0];
      b_q      <= sy_neg ? oy[BS-1:0] : ~oy[BS-1:0];
      adx_q    <= adx;
      ady_q    <= ady;
      sx_neg_q <= sx_neg;
      sy_neg_q <= sy_neg;
      line_q   <= line_id_i;
    end
  end

  assign ybe  = GRD_W'($signed(yb_q));
  assign eybe = GRD_W'($signed(eyb_q));
  assign gwe  = GRD_W'({1'b0, cfg_i.grid_width});

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      p1_q <= PRD_W'(a_q) * PRD_W'(ady_q);
      p2_q <= PRD_W'(b_q) * PRD_W'(adx_q);
      pc_q <= ybe * gwe;
      pe_q <= eybe * gwe;
    end
  end

  assign gwx = CUR_W'({1'b0, cfg_i.grid_width});

  // result decisions for the current block
  assign tot      = (cfg_i.grid_blocks < lbgw_pkg::GRID_CAP) ? cfg_i.grid_blocks
                                                             : lbgw_pkg::GRID_CAP;
  assign left     = cur_q[CUR_W-1] || (cur_q >= CUR_W'(tot));
  assign visit_nx = visit_q + VIS_W'(1);
  assign at_end   = (cur_q == end_q);
  assign at_cap   = (visit_nx >= lbgw_pkg::VIS_CAP);

  always_comb begin
    err_d = err_q;
    cur_d = cur_q;
    if (err_q[ERR_W-1]) begin
      err_d = err_q + ydel_q;
      cur_d = cur_q + (xneg_q ? {CUR_W{1'b1}} : CUR_W'(1));
    end else begin
      err_d = err_q - xdel_q;
      cur_d = cur_q + ystep_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum) begin
      if (adx_q == '0) begin
        err_q <= ERR_W'(1);
      end else if (ady_q == '0) begin
        err_q <= {ERR_W{1'b1}};
      end else begin
        err_q <= ERR_W'(p1_q) - ERR_W'(p2_q);
      end
      cur_q   <= CUR_W'(pc_q) + CUR_W'($signed(xb_q));
      end_q   <= CUR_W'(pe_q) + CUR_W'($signed(exb_q));
      xdel_q  <= ERR_W'({adx_q, {BS{1'b0}}});
      ydel_q  <= ERR_W'({ady_q, {BS{1'b0}}});
      xneg_q  <= sx_neg_q;
      ystep_q <= sy_neg_q ? (~gwx + CUR_W'(1)) : gwx;
      visit_q <= '0;
    end else if (cmd_i.emit && !(left || at_end || at_cap)) begin
      err_q   <= err_d;
      cur_q   <= cur_d;
      visit_q <= visit_nx;
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign sts_o.last     = left || at_end || at_cap;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      line_out_o <= line_q;
      if (left) begin
        idx_q  <= '0;
        vld_q  <= 1'b0;
        last_q <= 1'b1;
        st_q   <= lbgw_pkg::ST_LEFT;
      end else begin
        idx_q  <= cur_q[lbgw_pkg::IDX_W-1:0];
        vld_q  <= 1'b1;
        last_q <= at_end || at_cap;
        st_q   <= (!at_end && at_cap) ? lbgw_pkg::ST_CAP : lbgw_pkg::ST_OK;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign block_index_o = idx_q;
  assign block_valid_o = vld_q;
  assign last_o        = last_q;
  assign status_o      = st_q;

endmodule

@@ design/line_block_grid_walker_core.sv @@
// line_block_grid_walker_core: top level with configuration registers
// depends on lbgw_pkg, lbgw_ctrl and lbgw_dpath

// One segment is taken at a time. After it is accepted, the setup states S_MUL
// and S_SUM form the block indexes and the starting error term, then one result
// item per cycle leaves through the output register while the consumer takes
// it. The next segment is accepted in the cycle after the last result is
// produced, even while that result still waits to be taken. Configuration
// writes go straight into the registers and must come only while no segment
// is in work.
module line_block_grid_walker_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_index_i,
  input  logic [lbgw_pkg::CFG_W-1:0]  cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [lbgw_pkg::LID_W-1:0]  line_id_i,
  input  logic [lbgw_pkg::CRD_W-1:0]  start_x_i,
  input  logic [lbgw_pkg::CRD_W-1:0]  start_y_i,
  input  logic [lbgw_pkg::CRD_W-1:0]  end_x_i,
  input  logic [lbgw_pkg::CRD_W-1:0]  end_y_i,
  input  logic [lbgw_pkg::DLT_W-1:0]  delta_x_i,
  input  logic [lbgw_pkg::DLT_W-1:0]  delta_y_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [lbgw_pkg::LID_W-1:0]  line_out_o,
  output logic [lbgw_pkg::IDX_W-1:0]  block_index_o,
  output logic                        block_valid_o,
  output logic                        last_o,
  output logic [lbgw_pkg::ST_W-1:0]   status_o
);

  lbgw_pkg::cfg_t cfg_q;
  lbgw_pkg::cmd_t cmd;
  lbgw_pkg::sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_x    <= '0;
      cfg_q.origin_y    <= '0;
      cfg_q.grid_width  <= lbgw_pkg::GW_W'(1);
      cfg_q.grid_blocks <= lbgw_pkg::GB_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        lbgw_pkg::REG_ORIGIN_X:    cfg_q.origin_x    <= cfg_data_i[lbgw_pkg::ORG_W-1:0];
        lbgw_pkg::REG_ORIGIN_Y:    cfg_q.origin_y    <= cfg_data_i[lbgw_pkg::ORG_W-1:0];
        lbgw_pkg::REG_GRID_WIDTH:  cfg_q.grid_width  <= cfg_data_i[lbgw_pkg::GW_W-1:0];
        lbgw_pkg::REG_GRID_BLOCKS: cfg_q.grid_blocks <= cfg_data_i[lbgw_pkg::GB_W-1:0];
        default: ;
      endcase
    end
  end

  lbgw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lbgw_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .line_id_i     (line_id_i),
    .start_x_i     (start_x_i),
    .start_y_i     (start_y_i),
    .end_x_i       (end_x_i),
    .end_y_i       (end_y_i),
    .delta_x_i     (delta_x_i),
    .delta_y_i     (delta_y_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .line_out_o    (line_out_o),
    .block_index_o (block_index_o),
    .block_valid_o (block_valid_o),
    .last_o        (last_o),
    .status_o      (status_o)
  );

  a_no_emit_when_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> !in_ready_o)
    else $error("result produced while accepting items");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("ready right after accept");

  a_invalid_is_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !block_valid_o) |-> (last_o && status_o == lbgw_pkg::ST_LEFT))
    else $error("invalid block without left-grid end");

  a_stop_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != lbgw_pkg::ST_OK) |-> last_o)
    else $error("stop status on a non-final item");

  a_emit_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit && out_valid_o) |-> out_ready_i)
    else $error("result register overwritten");

endmodule

@@ sim/tb_line_block_grid_walker_core.sv @@
// tb_line_block_grid_walker_core: self-checking testbench of the grid line walker
// a clocked driver and monitor around u_dut check every block item against a predicted walk
// depends on lbgw_pkg and line_block_grid_walker_core
module tb_line_block_grid_walker_core;
  timeunit 1ns;
  timeprecision 1ps;

  import lbgw_pkg::*;

  typedef struct {
    logic [LID_W-1:0]        line_id;
    logic signed [CRD_W-1:0] start_x;
    logic signed [CRD_W-1:0] start_y;
    logic signed [CRD_W-1:0] end_x;
    logic signed [CRD_W-1:0] end_y;
    logic signed [DLT_W-1:0] delta_x;
    logic signed [DLT_W-1:0] delta_y;
  } segment_t;

  typedef struct {
    logic [LID_W-1:0] line_out;
    logic [IDX_W-1:0] block_index;
    logic             block_valid;
    logic             last;
    logic [ST_W-1:0]  status;
  } block_hit_t;

  typedef enum {PACE_FREE, PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH} pace_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [1:0]        cfg_index_i = REG_ORIGIN_X;
  logic [CFG_W-1:0]  cfg_data_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [LID_W-1:0]  line_id_i = '0;
  logic [CRD_W-1:0]  start_x_i = '0;
  logic [CRD_W-1:0]  start_y_i = '0;
  logic [CRD_W-1:0]  end_x_i = '0;
  logic [CRD_W-1:0]  end_y_i = '0;
  logic [DLT_W-1:0]  delta_x_i = '0;
  logic [DLT_W-1:0]  delta_y_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [LID_W-1:0]  line_out_o;
  logic [IDX_W-1:0]  block_index_o;
  logic              block_valid_o;
  logic              last_o;
  logic [ST_W-1:0]   status_o;

  cfg_t       grid_cfg;
  segment_t   seg_pending[$];
  segment_t   seg_next;
  segment_t   seg_seen;
  block_hit_t hits_due[$];
  block_hit_t hit_due;
  logic       seg_taken = 1'b0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         mismatches = 0;

  line_block_grid_walker_core u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .line_id_i    (line_id_i),
    .start_x_i    (start_x_i),
    .start_y_i    (start_y_i),
    .end_x_i      (end_x_i),
    .end_y_i      (end_y_i),
    .delta_x_i    (delta_x_i),
    .delta_y_i    (delta_y_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .line_out_o   (line_out_o),
    .block_index_o(block_index_o),
    .block_valid_o(block_valid_o),
    .last_o       (last_o),
    .status_o     (status_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic void add_hit(logic [LID_W-1:0] id, longint idx, logic ok, logic fin,
                                  logic [ST_W-1:0] st);
    block_hit_t h;
    h.line_out    = id;
    h.block_index = IDX_W'(idx);
    h.block_valid = ok;
    h.last        = fin;
    h.status      = st;
    hits_due.push_back(h);
  endfunction

  // expected block items of one segment under the current grid settings
  function automatic void walk_segment(segment_t s);
    longint units, x, y, ex, ey, adx, ady, sx, sy, fx, fy;
    longint err, cur, fin, ystep, gw, lim;
    int     visits;
    bit     done;
    units = longint'(1) << BLOCK_SHIFT;
    x   = longint'(s.start_x) - longint'($signed(grid_cfg.origin_x));
    y   = longint'(s.start_y) - longint'($signed(grid_cfg.origin_y));
    ex  = longint'(s.end_x) - longint'($signed(grid_cfg.origin_x));
    ey  = longint'(s.end_y) - longint'($signed(grid_cfg.origin_y));
    adx = longint'(s.delta_x);
    ady = longint'(s.delta_y);
    sx  = adx < 0 ? -1 : 1;
    sy  = ady < 0 ? -1 : 1;
    if (adx < 0) adx = -adx;
    if (ady < 0) ady = -ady;
    if (adx == 0) begin
      err = 1;
    end else if (ady == 0) begin
      err = -1;
    end else begin
      fx  = (x >>> BLOCK_SHIFT) * units + (sx > 0 ? units - 1 : 0) - x;
      fy  = (y >>> BLOCK_SHIFT) * units + (sy > 0 ? units - 1 : 0) - y;
      err = fx * ady * sx - fy * adx * sy;
    end
    gw    = longint'(grid_cfg.grid_width);
    cur   = (y >>> BLOCK_SHIFT) * gw + (x >>> BLOCK_SHIFT);
    fin   = (ey >>> BLOCK_SHIFT) * gw + (ex >>> BLOCK_SHIFT);
    ystep = sy * gw;
    lim   = longint'(grid_cfg.grid_blocks);
    if (lim > MAX_GRID_BLOCKS) lim = MAX_GRID_BLOCKS;
    visits = 0;
    done   = 1'b0;
    while (!done) begin
      if (cur < 0 || cur >= lim) begin
        add_hit(s.line_id, 0, 1'b0, 1'b1, ST_LEFT);
        done = 1'b1;
      end else begin
        visits++;
        if (cur == fin) begin
          add_hit(s.line_id, cur, 1'b1, 1'b1, ST_OK);
          done = 1'b1;
        end else if (visits >= MAX_VISITS) begin
          add_hit(s.line_id, cur, 1'b1, 1'b1, ST_CAP);
          done = 1'b1;
        end else begin
          add_hit(s.line_id, cur, 1'b1, 1'b0, ST_OK);
          if (err < 0) begin
            err += ady * units;
            cur += sx;
          end else begin
            err -= adx * units;
            cur += ystep;
          end
        end
      end
    end
  endfunction

  function automatic segment_t seg(longint id, longint x0, longint y0, longint x1, longint y1,
                                   longint dx, longint dy);
    segment_t s;
    s.line_id = LID_W'(id);
    s.start_x = CRD_W'(x0);
    s.start_y = CRD_W'(y0);
    s.end_x   = CRD_W'(x1);
    s.end_y   = CRD_W'(y1);
    s.delta_x = DLT_W'(dx);
    s.delta_y = DLT_W'(dy);
    return s;
  endfunction

  function automatic longint pick(longint lo, longint hi);
    return lo + longint'($urandom_range(32'(hi - lo)));
  endfunction

  function automatic longint fit_coord(longint v);
    return v < -32768 ? -32768 : (v > 32767 ? 32767 : v);
  endfunction

  function automatic segment_t make_noise();
    return seg($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endfunction

  // segment that starts inside the grid and whose deltas match its vertices, or noise if no such start fits
  function automatic segment_t make_track();
    longint cols, rows, lim, ox, oy, xlo, xhi, ylo, yhi, x0, y0, x1, y1, reach;
    cols = longint'(grid_cfg.grid_width);
    lim  = longint'(grid_cfg.grid_blocks);
    if (lim > MAX_GRID_BLOCKS) lim = MAX_GRID_BLOCKS;
    rows = cols != 0 ? lim / cols : 0;
    ox   = longint'($signed(grid_cfg.origin_x));
    oy   = longint'($signed(grid_cfg.origin_y));
    xlo  = fit_coord(ox);
    xhi  = fit_coord(ox + (cols << BLOCK_SHIFT) - 1);
    ylo  = fit_coord(oy);
    yhi  = fit_coord(oy + (rows << BLOCK_SHIFT) - 1);
    if (rows == 0 || xlo < ox || ylo < oy || xlo > xhi || ylo > yhi) return make_noise();
    x0    = pick(xlo, xhi);
    y0    = pick(ylo, yhi);
    reach = $urandom_range(9) == 0 ? 3000 : 300;
    x1    = fit_coord(x0 + pick(-reach, reach));
    y1    = fit_coord(y0 + pick(-reach, reach));
    return seg($urandom, x0, y0, x1, y1, x1 - x0, y1 - y0);
  endfunction

  function automatic segment_t make_random();
    segment_t s;
    int       roll;
    roll = $urandom_range(99);
    if (roll >= 90) return make_noise();
    s = make_track();
    if (roll >= 75) begin
      case ($urandom_range(2))
        0: s.delta_x = -s.delta_x;
        1: begin
          s.delta_x = s.delta_y;
          s.delta_y = DLT_W'($urandom);
        end
        default: s.delta_y = '0;
      endcase
    end
    return s;
  endfunction

  task automatic set_pace(pace_t p);
    send_idle_pct  = (p == PACE_SEND_IDLE) ? 74 : (p == PACE_BOTH) ? 31 : 0;
    recv_stall_pct = (p == PACE_RECV_STALL) ? 74 : (p == PACE_BOTH) ? 31 : 0;
  endtask

  task automatic write_reg(logic [1:0] idx, longint value);
    logic [CFG_W-1:0] data;
    data = CFG_W'($urandom);
    case (idx)
      REG_ORIGIN_X: begin
        data[ORG_W-1:0]   = value[ORG_W-1:0];
        grid_cfg.origin_x = value[ORG_W-1:0];
      end
      REG_ORIGIN_Y: begin
        data[ORG_W-1:0]   = value[ORG_W-1:0];
        grid_cfg.origin_y = value[ORG_W-1:0];
      end
      REG_GRID_WIDTH: begin
        data[GW_W-1:0]      = value[GW_W-1:0];
        grid_cfg.grid_width = value[GW_W-1:0];
      end
      default: begin
        data                 = value[GB_W-1:0];
        grid_cfg.grid_blocks = value[GB_W-1:0];
      end
    endcase
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
  endtask

  task automatic set_grid(longint ox, longint oy, longint gw, longint gb);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_GRID_WIDTH, gw);
    write_reg(REG_GRID_BLOCKS, gb);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic settle();
    while (seg_pending.size() != 0 || in_valid_i || hits_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic check_field(string name, longint due, longint got);
    if (due != got) begin
      mismatches++;
      $display("%0t: %s expected %0d got %0d", $time, name, due, got);
    end
  endtask

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || seg_taken)) begin
      if (seg_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        seg_next = seg_pending.pop_front();
        in_valid_i <= 1'b1;
        line_id_i  <= seg_next.line_id;
        start_x_i  <= seg_next.start_x;
        start_y_i  <= seg_next.start_y;
        end_x_i    <= seg_next.end_x;
        end_y_i    <= seg_next.end_y;
        delta_x_i  <= seg_next.delta_x;
        delta_y_i  <= seg_next.delta_y;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_ready_i <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    seg_taken <= in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        seg_seen.line_id = line_id_i;
        seg_seen.start_x = start_x_i;
        seg_seen.start_y = start_y_i;
        seg_seen.end_x   = end_x_i;
        seg_seen.end_y   = end_y_i;
        seg_seen.delta_x = delta_x_i;
        seg_seen.delta_y = delta_y_i;
        walk_segment(seg_seen);
      end
      if (out_valid_o && out_ready_i) begin
        if (hits_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected item expected none got line %0d index %0d",
                   $time, line_out_o, block_index_o);
        end else begin
          hit_due = hits_due.pop_front();
          check_field("line_out", hit_due.line_out, line_out_o);
          check_field("block_index", hit_due.block_index, block_index_o);
          check_field("block_valid", hit_due.block_valid, block_valid_o);
          check_field("last", hit_due.last, last_o);
          check_field("status", hit_due.status, status_o);
        end
      end
    end
  end

  initial begin
    grid_cfg = '{origin_x: '0, origin_y: '0, grid_width: GW_W'(1), grid_blocks: GB_W'(1)};
    set_pace(PACE_FREE);
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // single block grid after reset
    seg_pending.push_back(seg(16'h0000, 0, 0, 0, 0, 0, 0));
    seg_pending.push_back(seg(16'hFFFF, 127, 127, 127, 127, 0, 0));
    seg_pending.push_back(seg(1, -1, 0, -1, 0, 0, 0));
    seg_pending.push_back(seg(2, 0, 0, 200, 0, 200, 0));
    seg_pending.push_back(seg(3, 64, 64, 64, 300, 0, 236));
    settle();

    // empty grid, then zero width
    set_grid(0, 0, 0, 0);
    seg_pending.push_back(seg(4, 10, 10, 300, 10, 290, 0));
    settle();
    set_grid(0, 0, 0, 100);
    seg_pending.push_back(seg(5, 10, 10, 300, 500, 0, 490));
    settle();

    set_grid(-1024, -1024, 16, 256);
    seg_pending.push_back(seg(6, 0, 0, 0, 600, 0, 600));
    seg_pending.push_back(seg(7, 0, 0, -700, 0, -700, 0));
    seg_pending.push_back(seg(8, 500, 500, -500, -300, -1000, -800));
    seg_pending.push_back(seg(9, -1, -1, 0, 0, 1, 1));
    seg_pending.push_back(seg(10, -129, -129, -128, -128, 1, 1));
    seg_pending.push_back(seg(11, 0, 900, 0, 1500, 0, 600));
    seg_pending.push_back(seg(12, -1024, -1024, 1023, 1023, 1, 0));
    seg_pending.push_back(seg(13, -1024, -1024, 1023, 1023, 2047, 2047));
    seg_pending.push_back(seg(14, 0, 0, -100, 100, -65536, 65535));
    seg_pending.push_back(seg(15, 32767, -32768, 0, 0, -32767, 32768));
    seg_pending.push_back(seg(16, -32768, 32767, 0, 0, 32768, -32767));
    seg_pending.push_back(seg(17, 300, -300, 300, -300, 65535, -65536));
    settle();

    set_grid(-65536, -65536, 1000, 524287);
    seg_pending.push_back(seg(18, -32768, -32768, -32000, -32768, 768, 0));
    seg_pending.push_back(seg(19, -32768, -32768, -32768, -32000, 0, 768));
    settle();
    set_grid(65535, 65535, 1023, 524287);
    seg_pending.push_back(seg(20, 32767, 32767, 32767, 32767, 0, 0));
    settle();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          set_grid(-32776, -32768, 512, 262144);
          set_pace(PACE_SEND_IDLE);
        end
        1: begin
          set_grid(0, 0, 16, 256);
          set_pace(PACE_RECV_STALL);
        end
        2: begin
          set_grid(1234, -4321, 37, 851);
          set_pace(PACE_BOTH);
        end
        3: begin
          set_grid(32767, 32767, 1, 1);
          set_pace(PACE_FREE);
        end
        default: begin
          set_grid(-300, -300, 1023, 524287);
          set_pace(PACE_BOTH);
        end
      endcase
      repeat (38) seg_pending.push_back(make_random());
      settle();
    end

    repeat (10) @(posedge clk_i);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
